// File: hdl/chunk_pool_free_list_allocator_unit_macros.svh
// ---------------------------------------------------------------------------
// Chunk pool allocator assertion macros
// Concurrent assertion shorthands for the allocator block.
// ---------------------------------------------------------------------------
`ifndef CHUNK_POOL_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define CHUNK_POOL_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define CPFL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cpfl assertion failed");

// next-cycle implication
`define CPFL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cpfl assertion failed");

`endif

// File: hdl/cpfl_pkg.sv
// ---------------------------------------------------------------------------
// Chunk pool allocator package
// Sizes, codes and the controller command bundle shared by the design modules.
// ---------------------------------------------------------------------------
package cpfl_pkg;

   localparam int NUM_POOLS  = 2;
   localparam int MAX_CHUNKS = 1024;

   localparam int POOL_W     = 1;
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 2;
   localparam int CHUNK_W    = $clog2(MAX_CHUNKS);
   localparam int COUNT_W    = $clog2(MAX_CHUNKS + 1);
   localparam int BYTES_W    = 17;
   localparam int OFFSET_W   = 26;
   localparam int PROD_W     = CHUNK_W + BYTES_W;
   localparam int LINK_AW    = POOL_W + CHUNK_W;
   localparam int LINK_DEPTH = NUM_POOLS * MAX_CHUNKS;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = BYTES_W;

   localparam logic [COUNT_W-1:0] CHUNKS_RESET = COUNT_W'(MAX_CHUNKS);
   localparam logic [BYTES_W-1:0] BYTES_RESET  = BYTES_W'(64);

   typedef enum logic [OP_W-1:0] {
      OP_INIT  = 2'd0,
      OP_ALLOC = 2'd1,
      OP_FREE  = 2'd2,
      OP_NONE  = 2'd3
   } cpfl_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_RANGE = 2'd2,
      ST_FULL  = 2'd3
   } cpfl_status_type;

   localparam logic [CSR_IDX_W-1:0] REG_P0_CHUNKS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_P1_CHUNKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_P0_BYTES  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_P1_BYTES  = 2'd3;

   typedef struct packed {
      logic capture;   // request taken this edge, link read issued
      logic execute;   // pool state update and result capture
   } cpfl_cmd_type;

endpackage

// File: hdl/chunk_pool_free_list_allocator_unit.sv
// ---------------------------------------------------------------------------
// Chunk pool free-list allocator
// Two pools of fixed-size chunks, each with a LIFO list of freed chunks and
// a watermark for never-used ones. Requests initialise, allocate or free.
// ---------------------------------------------------------------------------
//
//  channel   ports                                  handshake
//  -------   -----------------------------------    ---------------------------
//  request   req_opcode, req_pool, req_chunk_in     start & !busy at clock edge
//  result    rsp_status, rsp_chunk_out,             rsp_strobe, one cycle,
//            rsp_byte_offset, rsp_free_count        no back-pressure
//  csr       csr_index, csr_wdata                   csr_wr_en at clock edge
//
//  A request is accepted, then executed: the accepting edge reads the link
//  memory at the pool's list head, the next edge updates the pool and
//  registers the result; the synchronous link read is why they are split.
//  The result beat shows for one cycle with busy low, so a new request can
//  be taken on the edge that ends the beat. The receiver cannot stall.
//  Synchronous reset: pools come up initialised from the reset config.
//
`include "chunk_pool_free_list_allocator_unit_macros.svh"

module chunk_pool_free_list_allocator_unit
   import cpfl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request
   input  logic                  start,
   output logic                  busy,
   input  logic [OP_W-1:0]       req_opcode,
   input  logic [POOL_W-1:0]     req_pool,
   input  logic [CHUNK_W-1:0]    req_chunk_in,
   // result
   output logic                  rsp_strobe,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [CHUNK_W-1:0]    rsp_chunk_out,
   output logic [OFFSET_W-1:0]   rsp_byte_offset,
   output logic [COUNT_W-1:0]    rsp_free_count,
   // configuration
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cpfl_cmd_type cmd;

   // sequencer: accept, execute, strobe
   cpfl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   // list state, link memory and offset multiply
   cpfl_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_opcode      (req_opcode),
      .req_pool        (req_pool),
      .req_chunk_in    (req_chunk_in),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_status      (rsp_status),
      .rsp_chunk_out   (rsp_chunk_out),
      .rsp_byte_offset (rsp_byte_offset),
      .rsp_free_count  (rsp_free_count)
   );

   // ---------------- assertions ----------------
   // an accepted beat always occupies the execute cycle
   `CPFL_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // every execute cycle yields exactly one result beat
   `CPFL_ASSERT_NEXT(a_busy_strobe, clock, reset, busy, rsp_strobe && !busy)
   // a result is never shown while a request is in execution
   `CPFL_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_strobe, !busy)
   // free count never exceeds the largest pool
   `CPFL_ASSERT_NOW(a_count_range, clock, reset, rsp_strobe, rsp_free_count <= COUNT_W'(MAX_CHUNKS))

endmodule

// File: hdl/cpfl_ctrl.sv
// ---------------------------------------------------------------------------
// Chunk pool allocator controller
// Two-state sequencer: accept, then execute; drives busy and result strobe.
// ---------------------------------------------------------------------------
module cpfl_ctrl
   import cpfl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output logic         rsp_strobe,
   output cpfl_cmd_type cmd
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      strobe_ff, strobe_in;

   always_comb begin
      state_in  = state_ff;
      busy_in   = busy_ff;
      strobe_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_EXEC;
               busy_in  = 1'b1;
            end
         end
         S_EXEC: begin
            state_in  = S_IDLE;
            busy_in   = 1'b0;
            strobe_in = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= busy_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy        = busy_ff;
   assign rsp_strobe  = strobe_ff;
   assign cmd.capture = start & ~busy_ff;
   assign cmd.execute = (state_ff == S_EXEC);

endmodule

// File: hdl/cpfl_datapath.sv
// ---------------------------------------------------------------------------
// Chunk pool allocator datapath
// Config registers, per-pool list state, link memory and offset multiplier.
// ---------------------------------------------------------------------------
module cpfl_datapath
   import cpfl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cpfl_cmd_type          cmd,
   input  logic [OP_W-1:0]       req_opcode,
   input  logic [POOL_W-1:0]     req_pool,
   input  logic [CHUNK_W-1:0]    req_chunk_in,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [CHUNK_W-1:0]    rsp_chunk_out,
   output logic [OFFSET_W-1:0]   rsp_byte_offset,
   output logic [COUNT_W-1:0]    rsp_free_count
);

   // configuration
   logic [COUNT_W-1:0] cfg_chunks_ff [NUM_POOLS];
   logic [BYTES_W-1:0] cfg_bytes_ff  [NUM_POOLS];

   // per-pool list state
   logic [COUNT_W-1:0] cap_ff  [NUM_POOLS], cap_in  [NUM_POOLS];
   logic [BYTES_W-1:0] size_ff [NUM_POOLS], size_in [NUM_POOLS];
   logic [CHUNK_W-1:0] head_ff [NUM_POOLS], head_in [NUM_POOLS];
   logic [COUNT_W-1:0] len_ff  [NUM_POOLS], len_in  [NUM_POOLS];
   logic [COUNT_W-1:0] wm_ff   [NUM_POOLS], wm_in   [NUM_POOLS];
   logic [COUNT_W-1:0] fl_ff   [NUM_POOLS], fl_in   [NUM_POOLS];

   // captured request
   logic [OP_W-1:0]    op_ff;
   logic [POOL_W-1:0]  pool_ff;
   logic [CHUNK_W-1:0] chunk_ff;

   // link memory
   logic [CHUNK_W-1:0] link_mem [LINK_DEPTH];
   logic [CHUNK_W-1:0] link_rd_ff;
   logic               link_we;
   logic [LINK_AW-1:0] link_waddr;
   logic [CHUNK_W-1:0] link_wdata;
   logic [LINK_AW-1:0] link_raddr;

   // result registers
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [CHUNK_W-1:0]  idx_ff, idx_in;
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;

   logic [COUNT_W-1:0]  init_n;

   // ---------------- configuration writes ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_chunks_ff[0] <= CHUNKS_RESET;
         cfg_chunks_ff[1] <= CHUNKS_RESET;
         cfg_bytes_ff[0]  <= BYTES_RESET;
         cfg_bytes_ff[1]  <= BYTES_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_P0_CHUNKS: cfg_chunks_ff[0] <= csr_wdata[COUNT_W-1:0];
            REG_P1_CHUNKS: cfg_chunks_ff[1] <= csr_wdata[COUNT_W-1:0];
            REG_P0_BYTES:  cfg_bytes_ff[0]  <= csr_wdata;
            REG_P1_BYTES:  cfg_bytes_ff[1]  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- request capture and link read ----------------
   assign link_raddr = {req_pool, head_ff[req_pool]};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_opcode;
         pool_ff    <= req_pool;
         chunk_ff   <= req_chunk_in;
         link_rd_ff <= link_mem[link_raddr];
      end
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
   end

   // chunk count clamped to 1..MAX_CHUNKS
   always_comb begin
      init_n = cfg_chunks_ff[pool_ff];
      if (init_n == '0) begin
         init_n = COUNT_W'(1);
      end else if (init_n > CHUNKS_RESET) begin
         init_n = CHUNKS_RESET;
      end
   end

   // ---------------- execute ----------------
   always_comb begin
      cap_in     = cap_ff;
      size_in    = size_ff;
      head_in    = head_ff;
      len_in     = len_ff;
      wm_in      = wm_ff;
      fl_in      = fl_ff;
      status_in  = ST_OK;
      idx_in     = '0;
      cnt_in     = fl_ff[pool_ff];
      link_we    = 1'b0;
      link_waddr = {pool_ff, chunk_ff};
      link_wdata = (len_ff[pool_ff] != '0) ? head_ff[pool_ff] : '0;
      if (cmd.execute) begin
         case (cpfl_op_type'(op_ff))
            OP_INIT: begin
               cap_in[pool_ff]  = init_n;
               size_in[pool_ff] = cfg_bytes_ff[pool_ff];
               head_in[pool_ff] = '0;
               len_in[pool_ff]  = '0;
               wm_in[pool_ff]   = '0;
               fl_in[pool_ff]   = init_n;
               cnt_in           = init_n;
            end
            OP_ALLOC: begin
               if (fl_ff[pool_ff] == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  if (len_ff[pool_ff] != '0) begin
                     idx_in           = head_ff[pool_ff];
                     head_in[pool_ff] = link_rd_ff;
                     len_in[pool_ff]  = len_ff[pool_ff] - COUNT_W'(1);
                  end else begin
                     idx_in          = wm_ff[pool_ff][CHUNK_W-1:0];
                     wm_in[pool_ff]  = wm_ff[pool_ff] + COUNT_W'(1);
                  end
                  fl_in[pool_ff] = fl_ff[pool_ff] - COUNT_W'(1);
                  cnt_in         = fl_ff[pool_ff] - COUNT_W'(1);
               end
            end
            OP_FREE: begin
               if (COUNT_W'(chunk_ff) >= cap_ff[pool_ff]) begin
                  status_in = ST_RANGE;
               end else if (fl_ff[pool_ff] >= cap_ff[pool_ff]) begin
                  status_in = ST_FULL;
               end else begin
                  link_we          = 1'b1;
                  head_in[pool_ff] = chunk_ff;
                  len_in[pool_ff]  = len_ff[pool_ff] + COUNT_W'(1);
                  fl_in[pool_ff]   = fl_ff[pool_ff] + COUNT_W'(1);
                  cnt_in           = fl_ff[pool_ff] + COUNT_W'(1);
                  idx_in           = chunk_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign prod_in = PROD_W'(idx_in) * PROD_W'(size_ff[pool_ff]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= '{default: CHUNKS_RESET};
         size_ff <= '{default: BYTES_RESET};
         head_ff <= '{default: '0};
         len_ff  <= '{default: '0};
         wm_ff   <= '{default: '0};
         fl_ff   <= '{default: CHUNKS_RESET};
      end else begin
         cap_ff  <= cap_in;
         size_ff <= size_in;
         head_ff <= head_in;
         len_ff  <= len_in;
         wm_ff   <= wm_in;
         fl_ff   <= fl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff <= status_in;
         idx_ff    <= idx_in;
         cnt_ff    <= cnt_in;
         prod_ff   <= prod_in;
      end
   end

   // offset saturates at all ones
   assign rsp_byte_offset = (|prod_ff[PROD_W-1:OFFSET_W]) ? '1 : prod_ff[OFFSET_W-1:0];
   assign rsp_status      = status_ff;
   assign rsp_chunk_out   = idx_ff;
   assign rsp_free_count  = cnt_ff;

endmodule
